### hw/rtl/bmd_pkg.sv
// Shared constants, codes and helper functions of the braille matrix display.
// The Latin-1 to cell translation and the LED row mapping live here.
// No dependencies.
package bmd_pkg;

  localparam int LINE_DEPTH_DEF = 256;
  localparam int CELLS_PER_LINE = 10;
  localparam int CELL_W         = 6;
  localparam int WORD_W         = CELLS_PER_LINE * CELL_W;
  localparam int COL_W          = 4;
  localparam int ROW_W          = 3;

  // func selector codes
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_NAV   = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // navigate commands
  localparam logic [1:0] NAV_NEXT  = 2'd0;
  localparam logic [1:0] NAV_PREV  = 2'd1;
  localparam logic [1:0] NAV_FIRST = 2'd2;

  localparam logic [CELL_W-1:0] UNLISTED_CELL = 6'd62;

  typedef struct packed {
    logic we;
    logic re;
  } bmd_mem_ctl_t;

  // Six-dot cell for a Latin-1 code, bit d-1 holds dot d.
  function automatic logic [CELL_W-1:0] cell_of(input logic [7:0] code);
    logic [CELL_W-1:0] c;
    case (code)
      8'd32:                  c = 6'd0;
      8'd33, 8'd43:           c = 6'd22;
      8'd34, 8'd168:          c = 6'd38;
      8'd36, 8'd37:           c = 6'd56;
      8'd38, 8'd47:           c = 6'd32;
      8'd40:                  c = 6'd35;
      8'd41:                  c = 6'd28;
      8'd42:                  c = 6'd20;
      8'd44:                  c = 6'd2;
      8'd45:                  c = 6'd36;
      8'd46:                  c = 6'd4;
      8'd48, 8'd106:          c = 6'd26;
      8'd49, 8'd97, 8'd170:   c = 6'd1;
      8'd50, 8'd98:           c = 6'd3;
      8'd51, 8'd99:           c = 6'd9;
      8'd52, 8'd100:          c = 6'd25;
      8'd53, 8'd101:          c = 6'd17;
      8'd54, 8'd102:          c = 6'd11;
      8'd55, 8'd103:          c = 6'd27;
      8'd56, 8'd104:          c = 6'd19;
      8'd57, 8'd105:          c = 6'd10;
      8'd58:                  c = 6'd18;
      8'd59:                  c = 6'd6;
      8'd60, 8'd64:           c = 6'd16;
      8'd61:                  c = 6'd54;
      8'd62:                  c = 6'd40;
      8'd63, 8'd161, 8'd191:  c = 6'd34;
      8'd107:                 c = 6'd5;
      8'd108:                 c = 6'd7;
      8'd109:                 c = 6'd13;
      8'd110:                 c = 6'd29;
      8'd111, 8'd186:         c = 6'd21;
      8'd112:                 c = 6'd15;
      8'd113:                 c = 6'd31;
      8'd114:                 c = 6'd23;
      8'd115:                 c = 6'd14;
      8'd116:                 c = 6'd30;
      8'd117:                 c = 6'd37;
      8'd118:                 c = 6'd39;
      8'd119:                 c = 6'd58;
      8'd120:                 c = 6'd45;
      8'd121, 8'd241:         c = 6'd59;
      8'd122:                 c = 6'd53;
      8'd176:                 c = 6'd52;
      8'd225:                 c = 6'd55;
      8'd233:                 c = 6'd63;
      8'd237:                 c = 6'd12;
      8'd243:                 c = 6'd44;
      8'd250:                 c = 6'd62;
      default:                c = UNLISTED_CELL;
    endcase
    return c;
  endfunction

  // Column dots of one matrix row taken from a stored line word.
  function automatic logic [7:0] row_columns(input logic [WORD_W-1:0] word,
                                             input logic [ROW_W-1:0] row);
    logic [7:0] d;
    d = 8'd0;
    case (row)
      3'd6: d = {2'b00, word[59], word[58], word[57], word[53], word[52], word[51]};
      3'd7: d = {2'b00, word[56], word[55], word[54], word[50], word[49], word[48]};
      default: begin
        for (int j = 0; j < 8; j++) begin
          // rows 0..2 start at bit r, rows 3..5 at bit r+21, step of three
          d[j] = word[((row < 3'd3) ? 6'(row) : 6'(row) + 6'd21) + 6'(3 * j)];
        end
      end
    endcase
    return d;
  endfunction

endpackage

### hw/rtl/bmd_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module bmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/bmd_ctrl.sv
// Sequencer of the braille matrix display: cursor and view registers,
// read-modify-write of line words, row scan and the result register.
// Depends on bmd_pkg.
module bmd_ctrl
  import bmd_pkg::*;
#(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [1:0]                    req_func,
  input  logic [7:0]                    req_char,
  input  logic [1:0]                    req_nav,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [7:0]                    res_row_select,
  output logic [7:0]                    res_column_data,
  output logic [ROW_W-1:0]              res_row_index,
  output bmd_mem_ctl_t                  mem_ctl,
  output logic [$clog2(LINE_DEPTH)-1:0] mem_waddr,
  output logic [WORD_W-1:0]             mem_wdata,
  output logic [$clog2(LINE_DEPTH)-1:0] mem_raddr,
  input  logic [WORD_W-1:0]             mem_rdata
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int LW = $clog2(LINE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WB   = 2'd1;
  localparam logic [1:0] ST_TICK = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [LW-1:0]     write_line_r, write_line_nxt;
  logic [COL_W-1:0]  write_column_r, write_column_nxt;
  logic [AW-1:0]     view_line_r, view_line_nxt;
  logic [ROW_W-1:0]  scan_row_r, scan_row_nxt;
  logic [CELL_W-1:0] cell_r, cell_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_sel_r, out_sel_nxt;
  logic [7:0]        out_col_r, out_col_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;

  logic              accept;
  logic              store_full;
  logic [5:0]        shamt;
  logic [WORD_W-1:0] cell_mask;
  logic [WORD_W-1:0] cell_word;

  assign store_full = (write_line_r == LW'(LINE_DEPTH));
  // one request in flight; result register must be free when a tick lands
  assign req_ready  = (state_r == ST_IDLE) && (!out_valid_r || res_ready);
  assign accept     = req_valid && req_ready;

  assign shamt     = 6'(write_column_r) * 6'(CELL_W);
  assign cell_mask = {{(WORD_W-CELL_W){1'b0}}, {CELL_W{1'b1}}} << shamt;
  assign cell_word = {{(WORD_W-CELL_W){1'b0}}, cell_r} << shamt;

  assign mem_ctl.re = accept;
  assign mem_ctl.we = (state_r == ST_WB);
  assign mem_raddr  = (req_func == FUNC_WRITE) ? write_line_r[AW-1:0] : view_line_r;
  assign mem_waddr  = write_line_r[AW-1:0];
  assign mem_wdata  = (mem_rdata & ~cell_mask) | cell_word;

  always_comb begin
    state_nxt        = state_r;
    write_line_nxt   = write_line_r;
    write_column_nxt = write_column_r;
    view_line_nxt    = view_line_r;
    scan_row_nxt     = scan_row_r;
    cell_nxt         = cell_r;
    out_valid_nxt    = out_valid_r && !res_ready;
    out_sel_nxt      = out_sel_r;
    out_col_nxt      = out_col_r;
    out_row_nxt      = out_row_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (req_func)
            FUNC_WRITE: begin
              if (!store_full) begin
                cell_nxt  = cell_of(req_char);
                state_nxt = ST_WB;
              end
            end
            FUNC_NAV: begin
              case (req_nav)
                NAV_NEXT: begin
                  if ((LW + 1)'(view_line_r) + (LW + 1)'(1) < (LW + 1)'(write_line_r)) begin
                    view_line_nxt = view_line_r + AW'(1);
                  end
                end
                NAV_PREV: begin
                  if (view_line_r != '0) begin
                    view_line_nxt = view_line_r - AW'(1);
                  end
                end
                NAV_FIRST: view_line_nxt = '0;
                default: ;
              endcase
            end
            FUNC_TICK: state_nxt = ST_TICK;
            default: ;
          endcase
        end
      end
      ST_WB: begin
        // merged word goes back this cycle
        if (write_column_r == COL_W'(CELLS_PER_LINE - 1)) begin
          write_column_nxt = '0;
          write_line_nxt   = write_line_r + LW'(1);
        end else begin
          write_column_nxt = write_column_r + COL_W'(1);
        end
        state_nxt = ST_IDLE;
      end
      ST_TICK: begin
        out_valid_nxt = 1'b1;
        out_sel_nxt   = ~(8'd1 << scan_row_r);
        out_col_nxt   = row_columns(mem_rdata, scan_row_r);
        out_row_nxt   = scan_row_r;
        scan_row_nxt  = scan_row_r + ROW_W'(1);
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      write_line_r   <= '0;
      write_column_r <= '0;
      view_line_r    <= '0;
      scan_row_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      write_line_r   <= write_line_nxt;
      write_column_r <= write_column_nxt;
      view_line_r    <= view_line_nxt;
      scan_row_r     <= scan_row_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_r    <= cell_nxt;
    out_sel_r <= out_sel_nxt;
    out_col_r <= out_col_nxt;
    out_row_r <= out_row_nxt;
  end

  assign res_valid       = out_valid_r;
  assign res_row_select  = out_sel_r;
  assign res_column_data = out_col_r;
  assign res_row_index   = out_row_r;

endmodule

### hw/rtl/braille_matrix_display_top.sv
// Braille matrix display: a request either writes one Latin-1 character as a
// six-dot cell into the line store (ten cells to a line), moves the viewed line,
// or scans one row of an 8x8 LED matrix showing the viewed line. A write reads
// the line word and writes the merged word back in a write-back state (not once
// the store is full); a scan tick reads it and loads the result in a tick state,
// as the line store RAM read is registered (a write is a read-modify-write of
// the 60-bit line word). Only ticks give a result, held in an output register;
// while that result waits for out_tready, no new request is taken. Writes are
// dropped once LINE_DEPTH lines are full. The store needs no clearing pass;
// lines read before being written are undefined.
// Depends on bmd_pkg, bmd_ram and bmd_ctrl.
module braille_matrix_display_top
  import bmd_pkg::*;
#(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] char_code, [9:8] nav_command, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [7:0] row_select, [15:8] column_data,
                                  // [18:16] row_index, rest zero
);

  localparam int AW = $clog2(LINE_DEPTH);

  bmd_mem_ctl_t      mem_ctl;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;
  logic [7:0]        row_select;
  logic [7:0]        column_data;
  logic [ROW_W-1:0]  row_index;

  bmd_ctrl #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (in_tvalid),
    .req_ready       (in_tready),
    .req_func        (in_tuser),
    .req_char        (in_tdata[7:0]),
    .req_nav         (in_tdata[9:8]),
    .res_valid       (out_tvalid),
    .res_ready       (out_tready),
    .res_row_select  (row_select),
    .res_column_data (column_data),
    .res_row_index   (row_index),
    .mem_ctl         (mem_ctl),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata)
  );

  bmd_ram #(
    .WIDTH(WORD_W),
    .DEPTH(LINE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (mem_ctl.we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_ctl.re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_tdata = {5'd0, row_index, column_data, row_select};

endmodule

### tb/tb_top.sv
// Testbench for braille_matrix_display_top: drives write, navigate and scan
// requests, predicts every scanned LED row and checks it field by field.
// Depends on bmd_pkg and the braille_matrix_display_top RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bmd_pkg::*;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam logic [1:0] NAV_NONE  = 2'd3;
  localparam int         STORE_LINES = LINE_DEPTH_DEF;

  typedef struct packed {
    logic [2:0] row_index;
    logic [7:0] column_data;
    logic [7:0] row_select;
  } scan_row_t;

  class scan_scoreboard;
    logic [WORD_W-1:0] lines [STORE_LINES];
    int unsigned       fill_line;
    int unsigned       fill_col;
    int unsigned       shown_line;
    logic [2:0]        next_row;
    scan_row_t         expected_rows [$];
    int unsigned       errors;

    function new();
      fill_line  = 0;
      fill_col   = 0;
      shown_line = 0;
      next_row   = 3'd0;
      errors     = 0;
    endfunction

    // Spanish six-dot cell, bit d-1 = dot d; anything unlisted is 2-3-4-5-6
    function logic [5:0] braille_dots(input logic [7:0] code);
      case (code)
        8'd32: return 6'd0;
        8'd33, 8'd43: return 6'd22;
        8'd34, 8'd168: return 6'd38;
        8'd36, 8'd37: return 6'd56;
        8'd38, 8'd47: return 6'd32;
        8'd40: return 6'd35;
        8'd41: return 6'd28;
        8'd42: return 6'd20;
        8'd44: return 6'd2;
        8'd45: return 6'd36;
        8'd46: return 6'd4;
        8'd48, 8'd106: return 6'd26;
        8'd49, 8'd97, 8'd170: return 6'd1;
        8'd50, 8'd98: return 6'd3;
        8'd51, 8'd99: return 6'd9;
        8'd52, 8'd100: return 6'd25;
        8'd53, 8'd101: return 6'd17;
        8'd54, 8'd102: return 6'd11;
        8'd55, 8'd103: return 6'd27;
        8'd56, 8'd104: return 6'd19;
        8'd57, 8'd105: return 6'd10;
        8'd58: return 6'd18;
        8'd59: return 6'd6;
        8'd60, 8'd64: return 6'd16;
        8'd61: return 6'd54;
        8'd62: return 6'd40;
        8'd63, 8'd161, 8'd191: return 6'd34;
        8'd107: return 6'd5;
        8'd108: return 6'd7;
        8'd109: return 6'd13;
        8'd110: return 6'd29;
        8'd111, 8'd186: return 6'd21;
        8'd112: return 6'd15;
        8'd113: return 6'd31;
        8'd114: return 6'd23;
        8'd115: return 6'd14;
        8'd116: return 6'd30;
        8'd117: return 6'd37;
        8'd118: return 6'd39;
        8'd119: return 6'd58;
        8'd120: return 6'd45;
        8'd121, 8'd241: return 6'd59;
        8'd122: return 6'd53;
        8'd176: return 6'd52;
        8'd225: return 6'd55;
        8'd233: return 6'd63;
        8'd237: return 6'd12;
        8'd243: return 6'd44;
        8'd250: return 6'd62;
        default: return 6'd62;
      endcase
    endfunction

    function logic [7:0] scan_columns(input logic [WORD_W-1:0] word, input logic [2:0] row);
      logic [7:0] dots;
      int         base;
      dots = 8'd0;
      if (row < 3'd6) begin
        base = (row < 3'd3) ? int'(row) : int'(row) + 21;
        for (int j = 0; j < 8; j++) dots[j] = word[base + 3 * j];
      end else begin
        // rows 6/7 carry the last two cells: 51..53,57..59 and 48..50,54..56
        base = (row == 3'd6) ? 51 : 48;
        for (int j = 0; j < 6; j++) dots[j] = word[base + ((j < 3) ? j : j + 3)];
      end
      return dots;
    endfunction

    function void note_request(input logic [1:0] f, input logic [7:0] code,
                               input logic [1:0] nav);
      scan_row_t want;
      case (f)
        FUNC_WRITE: begin
          if (fill_line < STORE_LINES) begin
            lines[fill_line][fill_col * CELL_W +: CELL_W] = braille_dots(code);
            fill_col++;
            if (fill_col == CELLS_PER_LINE) begin
              fill_col = 0;
              fill_line++;
            end
          end
        end
        FUNC_NAV: begin
          case (nav)
            NAV_NEXT:  if (shown_line + 1 < fill_line) shown_line++;
            NAV_PREV:  if (shown_line > 0) shown_line--;
            NAV_FIRST: shown_line = 0;
            default: ;
          endcase
        end
        FUNC_TICK: begin
          want.row_select  = ~(8'd1 << next_row);
          want.column_data = scan_columns(lines[shown_line], next_row);
          want.row_index   = next_row;
          expected_rows.push_back(want);
          next_row++;
        end
        default: ;
      endcase
    endfunction

    function void check_scan(input logic [23:0] data);
      scan_row_t got, want;
      got = data[18:0];
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected scan row, expected none, got %06h", $time, data);
        errors++;
        return;
      end
      want = expected_rows.pop_front();
      if (got.row_select != want.row_select) begin
        $display("%0t: row_select expected %02h got %02h", $time, want.row_select,
                 got.row_select);
        errors++;
      end
      if (got.column_data != want.column_data) begin
        $display("%0t: column_data expected %02h got %02h", $time, want.column_data,
                 got.column_data);
        errors++;
      end
      if (got.row_index != want.row_index) begin
        $display("%0t: row_index expected %0d got %0d", $time, want.row_index,
                 got.row_index);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_rows.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;

  scan_scoreboard board;
  int unsigned    requests_sent;
  int unsigned    writes_sent;
  int unsigned    scans_seen;

  braille_matrix_display_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_scan(out_tdata);
      scans_seen++;
    end
  end

  // Result side: random back-pressure, one long hold-off, one quiet stretch.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (!hold_done && scans_seen >= 40) begin
        hold_left = 300;
        hold_done = 1;
        out_tready <= 1'b0;
      end else if (scans_seen >= 150 && scans_seen < 260) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= 16);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic [1:0] f, input logic [7:0] code,
                              input logic [1:0] nav);
    bit quiet;
    quiet = (requests_sent >= 400 && requests_sent < 550);
    while (!quiet && $urandom_range(0, 99) < 16) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, nav, code};
    in_tuser  <= f;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_request(f, code, nav);
    requests_sent++;
    if (f == FUNC_WRITE) writes_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] random_code();
    if ($urandom_range(0, 99) < 60) return 8'($urandom_range(32, 127));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [1:0] random_nav();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return NAV_NEXT;
    if (r < 75) return NAV_PREV;
    if (r < 88) return NAV_FIRST;
    return NAV_NONE;
  endfunction

  // Mixed traffic; a tick is only sent once the first line is complete, so
  // an unwritten line is never scanned.
  task automatic random_request(input int write_pct, input int nav_pct, input int tick_pct);
    int         pick;
    logic [1:0] f;
    pick = $urandom_range(0, 99);
    if (pick < write_pct) f = FUNC_WRITE;
    else if (pick < write_pct + nav_pct) f = FUNC_NAV;
    else if (pick < write_pct + nav_pct + tick_pct) f = FUNC_TICK;
    else f = FUNC_NONE;
    if (f == FUNC_TICK && writes_sent < CELLS_PER_LINE) f = FUNC_WRITE;
    send_request(f, random_code(), random_nav());
  endtask

  initial begin
    logic [7:0] first_line [10];
    board = new();
    requests_sent = 0;
    writes_sent = 0;
    scans_seen = 0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 16'd0;
    in_tuser  = FUNC_WRITE;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // code extremes, all-dots, unlisted and assorted listed characters
    first_line = '{8'h00, 8'hFF, 8'd32, 8'd233, 8'd250, 8'd97, 8'd122, 8'd176,
                   8'd241, 8'd63};
    foreach (first_line[i]) send_request(FUNC_WRITE, first_line[i], NAV_NEXT);
    send_request(FUNC_NAV, 8'hFF, NAV_NEXT);   // only one line: stays on line 0
    send_request(FUNC_NAV, 8'h00, NAV_PREV);   // already at the start
    send_request(FUNC_NAV, 8'h5A, NAV_FIRST);
    send_request(FUNC_NAV, 8'hA5, NAV_NONE);
    send_request(FUNC_NONE, 8'hFF, NAV_NONE);
    repeat (9) send_request(FUNC_TICK, 8'h00, NAV_FIRST);

    repeat (1000) random_request(45, 15, 35);

    // run next past the last completed line, then scan and step back
    repeat (60) send_request(FUNC_NAV, random_code(), NAV_NEXT);
    repeat (10) send_request(FUNC_TICK, random_code(), random_nav());
    repeat (3) send_request(FUNC_NAV, random_code(), NAV_PREV);
    repeat (5) random_request(50, 0, 50);
    repeat (8) send_request(FUNC_TICK, random_code(), random_nav());
    in_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
